### src/hrhc_pkg.sv
// Package for the HTTP request head checker: status, phase and URL codes,
// character constants and the keyword/URL step functions.
// No dependencies.
`default_nettype none

package hrhc_pkg;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_VALID      = 2'd1,
        ST_BAD        = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_GAP1    = 3'd1,
        PH_URL     = 3'd2,
        PH_GAP2    = 3'd3,
        PH_VERSION = 3'd4,
        PH_DOOMED  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        URL_UNDECIDED = 2'd0,
        URL_GOOD      = 2'd1,
        URL_BAD       = 2'd2,
        URL_PREFIX    = 2'd3
    } t_url;

    typedef enum logic [1:0] {
        KW_METHOD  = 2'd0,
        KW_VERSION = 2'd1,
        KW_SCHEME  = 2'd2
    } t_kw;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] LEN_METHOD  = 4'd3;
    localparam logic [3:0] LEN_VERSION = 4'd8;
    localparam logic [3:0] LEN_SCHEME  = 4'd7;

    // keyword match progress
    typedef struct packed {
        logic [3:0] pos;
        logic       mismatch;
    } t_kw_state;

    typedef struct packed {
        logic [3:0] pos;
        t_url       url;
    } t_url_state;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= "A" && b <= "Z") begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    // lowercase keyword characters; positions past the end are never compared
    function automatic logic [7:0] kw_char(input t_kw sel, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (sel)
            KW_METHOD: begin
                case (pos)
                    4'd0:    c = "g";
                    4'd1:    c = "e";
                    4'd2:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            KW_VERSION: begin
                case (pos)
                    4'd0:    c = "h";
                    4'd1:    c = "t";
                    4'd2:    c = "t";
                    4'd3:    c = "p";
                    4'd4:    c = "/";
                    4'd5:    c = "1";
                    4'd6:    c = ".";
                    4'd7:    c = "1";
                    default: c = 8'h00;
                endcase
            end
            KW_SCHEME: begin
                case (pos)
                    4'd0:    c = "h";
                    4'd1:    c = "t";
                    4'd2:    c = "t";
                    4'd3:    c = "p";
                    4'd4:    c = ":";
                    4'd5:    c = "/";
                    4'd6:    c = "/";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_kw_state kw_step(input logic [7:0] b, input t_kw_state s,
                                          input t_kw sel, input logic [3:0] len);
        t_kw_state r;
        r = s;
        if (!s.mismatch) begin
            if (s.pos < len && fold(b) == kw_char(sel, s.pos)) begin
                r.pos = s.pos + 4'd1;
            end else begin
                r.mismatch = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_url_state url_step(input logic [7:0] b, input t_url_state s);
        t_url_state r;
        r = s;
        if (s.url == URL_UNDECIDED) begin
            if (s.pos < LEN_SCHEME && fold(b) == kw_char(KW_SCHEME, s.pos)) begin
                r.pos = s.pos + 4'd1;
                if (r.pos == LEN_SCHEME) begin
                    r.url = URL_PREFIX;
                end
            end else begin
                r.url = (s.pos == 4'd0 && b == CH_SLASH) ? URL_GOOD : URL_BAD;
            end
        end else if (s.url == URL_PREFIX) begin
            if (b == CH_SLASH) begin
                r.url = URL_GOOD;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/http_request_head_checker.sv
// Top level of the HTTP request head checker: byte input register, parser
// state update and status output register. Depends on hrhc_pkg.
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_data_byte[7:0]
// status    out        o_valid / i_ready    o_status[1:0]
//
// One byte per cycle sustained while the status side keeps accepting; each
// byte's status lands in the output register by way of the input register
// and then the parser update into the output register.
// The parser state advances only when a byte moves from the input register
// into the output register, so stalls on either side freeze it.
// i_rst_n is synchronous, active low, and returns the parser to the start of
// a request with both registers empty.
module http_request_head_checker
    import hrhc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // output register
    logic       r_out_vld;
    t_status    r_status;

    // parser state
    logic       r_in_headers, n_in_headers;
    t_phase     r_phase,      n_phase;
    t_kw_state  r_kw,         n_kw;
    t_url       r_url,        n_url;
    logic       r_prev_cr,    n_prev_cr;
    logic       r_line_bytes, n_line_bytes;
    t_status    n_status;

    logic advance;

    // a byte moves forward when the output slot is free or being emptied
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;
    assign o_valid = r_out_vld;
    assign o_status = r_status;

    always_comb begin
        logic [7:0] b;
        t_url_state us;
        logic       line_ok;

        b            = r_in_byte;
        n_in_headers = r_in_headers;
        n_phase      = r_phase;
        n_kw         = r_kw;
        n_url        = r_url;
        n_prev_cr    = r_prev_cr;
        n_line_bytes = r_line_bytes;
        n_status     = ST_INCOMPLETE;
        us           = '{pos: r_kw.pos, url: r_url};

        line_ok = (r_phase == PH_VERSION) && (r_kw.pos == LEN_VERSION) &&
                  !r_kw.mismatch && (r_url == URL_GOOD);

        if (r_prev_cr) begin
            n_prev_cr = 1'b0;
            if (b != CH_LF) begin
                n_status = ST_BAD;
            end else if (r_in_headers) begin
                // empty header line ends the request
                if (!r_line_bytes) begin
                    n_status = ST_VALID;
                end
                n_line_bytes = 1'b0;
            end else if (line_ok) begin
                n_in_headers = 1'b1;
                n_line_bytes = 1'b0;
            end else begin
                n_status = ST_BAD;
            end
        end else if (b == CH_CR) begin
            n_prev_cr = 1'b1;
        end else if (b == CH_LF) begin
            n_status = ST_BAD;     // bare LF
        end else begin
            n_line_bytes = 1'b1;
            if (!r_in_headers) begin
                unique case (r_phase)
                    PH_METHOD: begin
                        if (is_blank(b)) begin
                            n_phase = (r_kw.pos == LEN_METHOD && !r_kw.mismatch)
                                      ? PH_GAP1 : PH_DOOMED;
                        end else begin
                            n_kw = kw_step(b, r_kw, KW_METHOD, LEN_METHOD);
                        end
                    end
                    PH_GAP1: begin
                        if (!is_blank(b)) begin
                            // first URL byte, matched from a fresh scheme state
                            n_phase     = PH_URL;
                            us          = url_step(b, t_url_state'{pos: 4'd0,
                                                                   url: URL_UNDECIDED});
                            n_kw.pos      = us.pos;
                            n_kw.mismatch = 1'b0;
                            n_url       = us.url;
                        end
                    end
                    PH_URL: begin
                        if (is_blank(b)) begin
                            n_phase = (r_url == URL_GOOD) ? PH_GAP2 : PH_DOOMED;
                        end else begin
                            us       = url_step(b, t_url_state'{pos: r_kw.pos, url: r_url});
                            n_kw.pos = us.pos;
                            n_url    = us.url;
                        end
                    end
                    PH_GAP2: begin
                        if (!is_blank(b)) begin
                            n_phase = PH_VERSION;
                            n_kw    = kw_step(b, t_kw_state'{pos: 4'd0, mismatch: 1'b0},
                                              KW_VERSION, LEN_VERSION);
                        end
                    end
                    PH_VERSION: begin
                        // trailing blanks count as version bytes
                        n_kw = kw_step(b, r_kw, KW_VERSION, LEN_VERSION);
                    end
                    default: begin
                        n_phase = PH_DOOMED;
                    end
                endcase
            end
        end

        // any verdict restarts the parser for the next request
        if (n_status != ST_INCOMPLETE) begin
            n_in_headers = 1'b0;
            n_phase      = PH_METHOD;
            n_kw         = '{pos: 4'd0, mismatch: 1'b0};
            n_url        = URL_UNDECIDED;
            n_prev_cr    = 1'b0;
            n_line_bytes = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_in_headers <= 1'b0;
            r_phase      <= PH_METHOD;
            r_kw         <= '{pos: 4'd0, mismatch: 1'b0};
            r_url        <= URL_UNDECIDED;
            r_prev_cr    <= 1'b0;
            r_line_bytes <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_out_vld    <= 1'b1;
                r_in_headers <= n_in_headers;
                r_phase      <= n_phase;
                r_kw         <= n_kw;
                r_url        <= n_url;
                r_prev_cr    <= n_prev_cr;
                r_line_bytes <= n_line_bytes;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire
